@@ src/point_in_box_first_hit_assert.svh @@
// Assertion macros used by the checker of this block.
// Each expects clk and arst_n in scope.
`ifndef POINT_IN_BOX_FIRST_HIT_ASSERT_SVH
`define POINT_IN_BOX_FIRST_HIT_ASSERT_SVH

// Same-cycle implication.
`define PIBFH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PIBFH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pibfh_pkg.sv @@
`timescale 1ns / 1ps

package pibfh_pkg;

	localparam int MAX_BOXES = 16;

	localparam int DATA_W = 32;
	localparam int BND_W  = DATA_W + 1;
	localparam int IDX_W  = 4;
	localparam int CFG_W  = 5;
	localparam int CNT_W  = $clog2(MAX_BOXES + 1);
	localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic signed [BND_W-1:0] lo_x;
		logic signed [BND_W-1:0] hi_x;
		logic signed [BND_W-1:0] lo_y;
		logic signed [BND_W-1:0] hi_y;
		logic signed [BND_W-1:0] lo_z;
		logic signed [BND_W-1:0] hi_z;
	} box_bnd_t;

	typedef struct packed {
		logic signed [BND_W-1:0] x;
		logic signed [BND_W-1:0] y;
		logic signed [BND_W-1:0] z;
	} pnt_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		box_bnd_t          data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

endpackage

@@ src/point_in_box_first_hit.sv @@
`timescale 1ns / 1ps
// Write transaction: stored in the box table at the accepting edge; req_stall stays low.
// Query transaction: scans boxes in index order up to box_count, capped at 16, and stops at
// the first hit; the shared box test reads one box a cycle from the single table read port.
// req_stall drops as rsp_valid rises, so the next transaction can be taken from then on;
// a response still stalled at the output holds a finished query back.
// Reset (arst_n low, asynchronous) clears box_count, the sequencer and the output register;
// the box table is not cleared and holds garbage until written.

module point_in_box_first_hit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                func,
	input  logic [pibfh_pkg::IDX_W-1:0]         box_index,
	input  logic signed [pibfh_pkg::DATA_W-1:0] center_x,
	input  logic signed [pibfh_pkg::DATA_W-1:0] center_y,
	input  logic signed [pibfh_pkg::DATA_W-1:0] center_z,
	input  logic signed [pibfh_pkg::DATA_W-1:0] half_x,
	input  logic signed [pibfh_pkg::DATA_W-1:0] half_y,
	input  logic signed [pibfh_pkg::DATA_W-1:0] half_z,
	input  logic signed [pibfh_pkg::DATA_W-1:0] point_x,
	input  logic signed [pibfh_pkg::DATA_W-1:0] point_y,
	input  logic signed [pibfh_pkg::DATA_W-1:0] point_z,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pibfh_pkg::CFG_W-1:0]         box_count,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                hit,
	output logic [pibfh_pkg::IDX_W-1:0]         hit_index
);
	import pibfh_pkg::*;

	mem_wr_t  wr;
	mem_rd_t  rd;
	box_bnd_t rd_data;
	pnt_t     point;
	logic     box_in;

	// Bounds are formed once at write time, with a guard bit so they never wrap
	always_comb begin
		wr.en        = req_valid && !req_stall && (func == FUNC_WRITE) &&
			($unsigned(box_index) < MAX_BOXES);
		wr.addr      = ADDR_W'(box_index);
		wr.data.lo_x = {center_x[DATA_W-1], center_x} - {half_x[DATA_W-1], half_x};
		wr.data.hi_x = {center_x[DATA_W-1], center_x} + {half_x[DATA_W-1], half_x};
		wr.data.lo_y = {center_y[DATA_W-1], center_y} - {half_y[DATA_W-1], half_y};
		wr.data.hi_y = {center_y[DATA_W-1], center_y} + {half_y[DATA_W-1], half_y};
		wr.data.lo_z = {center_z[DATA_W-1], center_z} - {half_z[DATA_W-1], half_z};
		wr.data.hi_z = {center_z[DATA_W-1], center_z} + {half_z[DATA_W-1], half_z};
	end

	pibfh_box_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	pibfh_box_test u_test (
		.bnd    (rd_data),
		.point  (point),
		.box_in (box_in)
	);

	pibfh_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.box_count (box_count),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.hit       (hit),
		.hit_index (hit_index),
		.rd        (rd),
		.point     (point),
		.box_in    (box_in)
	);

endmodule

@@ src/pibfh_box_mem.sv @@
`timescale 1ns / 1ps

module pibfh_box_mem (
	input  logic                clk,
	input  pibfh_pkg::mem_wr_t  wr,
	input  pibfh_pkg::mem_rd_t  rd,
	output pibfh_pkg::box_bnd_t rd_data
);
	import pibfh_pkg::*;

	box_bnd_t mem_q [MAX_BOXES];
	box_bnd_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/pibfh_box_test.sv @@
`timescale 1ns / 1ps

module pibfh_box_test (
	input  pibfh_pkg::box_bnd_t bnd,
	input  pibfh_pkg::pnt_t     point,
	output logic                box_in
);
	import pibfh_pkg::*;

	logic in_x;
	logic in_y;
	logic in_z;

	// Both bounds inclusive; a negative half extent gives lo > hi and never matches
	always_comb begin
		in_x   = (point.x >= bnd.lo_x) && (point.x <= bnd.hi_x);
		in_y   = (point.y >= bnd.lo_y) && (point.y <= bnd.hi_y);
		in_z   = (point.z >= bnd.lo_z) && (point.z <= bnd.hi_z);
		box_in = in_x && in_y && in_z;
	end

endmodule

@@ src/pibfh_seq.sv @@
`timescale 1ns / 1ps

module pibfh_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             func,
	input  logic signed [pibfh_pkg::DATA_W-1:0] point_x,
	input  logic signed [pibfh_pkg::DATA_W-1:0] point_y,
	input  logic signed [pibfh_pkg::DATA_W-1:0] point_z,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pibfh_pkg::CFG_W-1:0]      box_count,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic                             hit,
	output logic [pibfh_pkg::IDX_W-1:0]      hit_index,
	output pibfh_pkg::mem_rd_t               rd,
	output pibfh_pkg::pnt_t                  point,
	input  logic                             box_in
);
	import pibfh_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  box_count_q;
	logic [CNT_W-1:0]  scan_len;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic              found_q;
	logic [ADDR_W-1:0] found_idx_q;
	pnt_t              point_q;
	logic              rsp_valid_q;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_index_q;
	logic              query_acc;
	logic              box_hit;
	logic              issue;
	logic              rsp_free;

	always_comb begin
		scan_len  = (int'(box_count_q) > MAX_BOXES) ? CNT_W'(MAX_BOXES) : CNT_W'(box_count_q);
		query_acc = req_valid && (state_q == ST_IDLE) && (func == FUNC_QUERY);
		box_hit   = vld_s1 && box_in;
		issue     = (state_q == ST_SCAN) && !box_hit && (ptr_q != len_q);
		rsp_free  = !rsp_valid_q || !rsp_stall;
	end

	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rd.en     = issue;
	assign rd.addr   = ptr_q[ADDR_W-1:0];
	assign point     = point_q;
	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign hit_index = hit_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			box_count_q <= '0;
			len_q       <= '0;
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			point_q     <= '0;
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			hit_index_q <= '0;
		end else begin
			if (cfg_valid) begin
				box_count_q <= box_count;
			end
			// drop the response once the far side has taken it; in ST_DONE the reload decides
			if (rsp_valid_q && !rsp_stall && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query_acc) begin
						point_q.x <= BND_W'(0) - {point_x[DATA_W-1], point_x};
						point_q.y <= BND_W'(0) - {point_y[DATA_W-1], point_y};
						point_q.z <= BND_W'(0) - {point_z[DATA_W-1], point_z};
						len_q     <= scan_len;
						ptr_q     <= '0;
						vld_s1    <= 1'b0;
						found_q   <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// first match in index order wins, so stop on it
					if (box_hit) begin
						found_q     <= 1'b1;
						found_idx_q <= idx_s1;
						vld_s1      <= 1'b0;
						state_q     <= ST_DONE;
					end else if (ptr_q == len_q) begin
						vld_s1  <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						vld_s1 <= 1'b1;
						idx_s1 <= ptr_q[ADDR_W-1:0];
						ptr_q  <= ptr_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						hit_q       <= found_q;
						hit_index_q <= found_q ? IDX_W'(found_idx_q) : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/pibfh_checker.sv @@
`timescale 1ns / 1ps
`include "point_in_box_first_hit_assert.svh"

module pibfh_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic                        func,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input logic                        hit,
	input logic [pibfh_pkg::IDX_W-1:0] hit_index
);
	import pibfh_pkg::*;

	`PIBFH_ASSERT_NOW(a_miss_index_zero, rsp_valid && !hit, hit_index == '0, "miss with nonzero hit_index")
	`PIBFH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(hit) && $stable(hit_index), "stalled response changed")
	`PIBFH_ASSERT_NEXT(a_query_busy, req_valid && !req_stall && (func == FUNC_QUERY), req_stall, "query transaction did not occupy the block")
	`PIBFH_ASSERT_NEXT(a_write_single, req_valid && !req_stall && (func == FUNC_WRITE), !req_stall, "write transaction took more than one cycle")
	`PIBFH_ASSERT_NOW(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall), "response without a preceding query")

endmodule

bind point_in_box_first_hit pibfh_checker u_pibfh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.func      (func),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.hit       (hit),
	.hit_index (hit_index)
);

@@ test/point_in_box_first_hit_tb.sv @@
`timescale 1ns / 1ps

module point_in_box_first_hit_tb;
	import pibfh_pkg::*;

	localparam int        SETTLE_CYCLES  = 24;
	localparam int        WATCHDOG_LIMIT = 2000;
	localparam int        PHASE_ITEMS    = 190;
	localparam logic [31:0] MAX_POS      = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN_NEG      = 32'h8000_0000;
	localparam logic [31:0] ONE_Q        = 32'h0001_0000;
	localparam longint    Q_TOP          = 64'sd2147483648;
	localparam longint    Q_BOT          = -64'sd2147483647;

	typedef struct packed {
		logic                         func;
		logic [IDX_W-1:0]             slot;
		logic [2:0][DATA_W-1:0]       cen;
		logic [2:0][DATA_W-1:0]       half;
		logic [2:0][DATA_W-1:0]       pnt;
	} box_req_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] at;
	} box_hit_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	box_req_t         req_item = '0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_count = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	logic             hit;
	logic [IDX_W-1:0] hit_index;

	// stimulus side: the table as it will stand once queued writes have gone in
	logic [2:0][DATA_W-1:0] plan_cen  [MAX_BOXES];
	logic [2:0][DATA_W-1:0] plan_half [MAX_BOXES];

	// checking side: the table as the block holds it
	logic [2:0][DATA_W-1:0] tbl_cen  [MAX_BOXES];
	logic [2:0][DATA_W-1:0] tbl_half [MAX_BOXES];
	logic [CFG_W-1:0]       cur_count = '0;

	box_req_t req_backlog [$];
	box_hit_t hits_due [$];

	logic req_fire = 1'b0;
	int   n_queued = 0;
	int   n_taken = 0;
	int   n_writes = 0;
	int   n_queries = 0;
	int   n_hits = 0;
	int   n_errors = 0;
	int   idle_cycles = 0;
	int   burst_left = 1;
	int   gap_left = 0;
	int   rx_cycle = 0;
	int   rx_mode = 0;
	int   rx_run = 0;
	logic rx_hold = 1'b0;

	always #10 clk = ~clk;

	point_in_box_first_hit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (req_item.func),
		.box_index (req_item.slot),
		.center_x  (req_item.cen[0]),
		.center_y  (req_item.cen[1]),
		.center_z  (req_item.cen[2]),
		.half_x    (req_item.half[0]),
		.half_y    (req_item.half[1]),
		.half_z    (req_item.half[2]),
		.point_x   (req_item.pnt[0]),
		.point_y   (req_item.pnt[1]),
		.point_z   (req_item.pnt[2]),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.box_count (cfg_count),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.hit       (hit),
		.hit_index (hit_index)
	);

	// Negate the point and return the lowest scanned box holding it on all three axes.
	function automatic box_hit_t first_box_hit(input logic [2:0][DATA_W-1:0] pnt);
		box_hit_t res;
		int       n;
		logic     all_in;
		longint   q;
		longint   lo;
		longint   hi;
		res = '0;
		n = (cur_count > MAX_BOXES) ? MAX_BOXES : int'(cur_count);
		for (int i = 0; i < n; i++) begin
			all_in = 1'b1;
			for (int a = 0; a < 3; a++) begin
				q  = -longint'($signed(pnt[a]));
				lo = longint'($signed(tbl_cen[i][a])) - longint'($signed(tbl_half[i][a]));
				hi = longint'($signed(tbl_cen[i][a])) + longint'($signed(tbl_half[i][a]));
				if (q < lo || q > hi)
					all_in = 1'b0;
			end
			if (all_in && !res.hit) begin
				res.hit = 1'b1;
				res.at  = IDX_W'(i);
			end
		end
		return res;
	endfunction

	task automatic push_write(input int slot, input logic [2:0][DATA_W-1:0] cen,
			input logic [2:0][DATA_W-1:0] half);
		box_req_t item;
		item.func = FUNC_WRITE;
		item.slot = IDX_W'(slot);
		item.cen  = cen;
		item.half = half;
		item.pnt  = {$urandom, $urandom, $urandom};
		plan_cen[slot]  = cen;
		plan_half[slot] = half;
		req_backlog.push_back(item);
		n_queued++;
	endtask

	task automatic push_query(input logic [2:0][DATA_W-1:0] pnt);
		box_req_t item;
		item.func = FUNC_QUERY;
		item.slot = IDX_W'($urandom);
		item.cen  = {$urandom, $urandom, $urandom};
		item.half = {$urandom, $urandom, $urandom};
		item.pnt  = pnt;
		req_backlog.push_back(item);
		n_queued++;
	endtask

	task automatic rand_box(input int slot);
		logic [2:0][DATA_W-1:0] c;
		logic [2:0][DATA_W-1:0] h;
		int                     r;
		r = $urandom_range(0, 99);
		for (int a = 0; a < 3; a++) begin
			if (r < 60) begin
				c[a] = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
				h[a] = 32'($urandom_range(0, 1 << 20));
			end else if (r < 72) begin
				c[a] = $urandom;
				h[a] = $urandom >> 1;
			end else if (r < 82) begin
				case ($urandom_range(0, 2))
					0: c[a] = MAX_POS;
					1: c[a] = MIN_NEG;
					default: c[a] = '0;
				endcase
				case ($urandom_range(0, 3))
					0: h[a] = MAX_POS;
					1: h[a] = MIN_NEG;
					2: h[a] = '0;
					default: h[a] = '1;
				endcase
			end else begin
				c[a] = $urandom;
				h[a] = $urandom;
			end
		end
		// flip one axis inside out so the box can never be hit
		if (r >= 50 && r < 60)
			h[$urandom_range(0, 2)] = -32'($urandom_range(1, 1 << 20));
		push_write(slot, c, h);
	endtask

	task automatic rand_query(input int n);
		logic [2:0][DATA_W-1:0] pnt;
		int                     r;
		int                     j;
		longint                 lo;
		longint                 hi;
		longint                 q;
		longint                 tmp;
		r = $urandom_range(0, 99);
		j = (n > 0) ? $urandom_range(0, n - 1) : 0;
		for (int a = 0; a < 3; a++) begin
			if (n > 0 && r < 65) begin
				lo = longint'($signed(plan_cen[j][a])) - longint'($signed(plan_half[j][a]));
				hi = longint'($signed(plan_cen[j][a])) + longint'($signed(plan_half[j][a]));
				if (lo > hi) begin
					tmp = lo;
					lo  = hi;
					hi  = tmp;
				end
				case ($urandom_range(0, 11))
					0: q = lo;
					1: q = hi;
					2: q = lo - 1;
					3: q = hi + 1;
					default: q = lo + longint'({$urandom, $urandom} >> 1) % (hi - lo + 1);
				endcase
				// keep the negated target representable as a 32-bit point
				if (q > Q_TOP)
					q = Q_TOP;
				if (q < Q_BOT)
					q = Q_BOT;
				pnt[a] = 32'(-q);
			end else if (r < 85) begin
				pnt[a] = $urandom;
			end else begin
				pnt[a] = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
			end
		end
		push_query(pnt);
	endtask

	task automatic set_box_count(input int v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_count <= CFG_W'(v);
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (n_taken != n_queued || hits_due.size() != 0)
			@(posedge clk);
		// writes give no response, so let the block settle before touching the register
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: bursts of random length, random gaps between them
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				req_item  <= req_backlog.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 10);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: switch between no stall, scattered stalls and long runs
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 400 == 0)
			rx_mode = $urandom_range(0, 2);
		case (rx_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (rx_run == 0) begin
					rx_run  = $urandom_range(1, 16);
					rx_hold = ~rx_hold;
				end
				rx_run--;
				rsp_stall <= rx_hold;
			end
		endcase
	end

	always @(posedge clk) begin
		box_hit_t exp_hit;
		logic     fired;
		fired = 1'b0;
		req_fire <= req_valid && !req_stall;

		if (cfg_valid && cfg_ready) begin
			cur_count = cfg_count;
			fired = 1'b1;
		end

		if (req_valid && !req_stall) begin
			fired = 1'b1;
			n_taken++;
			if (req_item.func == FUNC_WRITE) begin
				tbl_cen[req_item.slot]  = req_item.cen;
				tbl_half[req_item.slot] = req_item.half;
				n_writes++;
			end else begin
				exp_hit = first_box_hit(req_item.pnt);
				hits_due.push_back(exp_hit);
				n_queries++;
				if (exp_hit.hit)
					n_hits++;
			end
		end

		if (rsp_valid && !rsp_stall) begin
			fired = 1'b1;
			if (hits_due.size() == 0) begin
				$display("%0t: response with none pending: hit %0b hit_index %0d",
					$time, hit, hit_index);
				n_errors++;
			end else begin
				exp_hit = hits_due.pop_front();
				if (hit !== exp_hit.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, exp_hit.hit, hit);
					n_errors++;
				end
				if (hit_index !== exp_hit.at) begin
					$display("%0t: hit_index expected %0d actual %0d",
						$time, exp_hit.at, hit_index);
					n_errors++;
				end
			end
		end

		idle_cycles = fired ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d responses outstanding",
				$time, idle_cycles, hits_due.size());
			$display("point_in_box_first_hit_tb failed");
			$finish;
		end
	end

	initial begin
		automatic int fixed_counts [6] = '{16, 31, 1, 0, 17, 8};
		int v;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty scan straight after reset
		push_query({32'd0, 32'd0, 32'd0});
		push_query({MIN_NEG, MIN_NEG, MIN_NEG});
		// slot 0 inside out, slot 1 a cube of half extent ONE_Q, slots 2 and 3 span the full range each side
		push_write(0, {3{32'd0}}, {3{32'hFFFF_FFFF}});
		push_write(1, {3{32'd0}}, {3{ONE_Q}});
		push_write(2, {3{MAX_POS}}, {3{MAX_POS}});
		push_write(3, {3{MIN_NEG}}, {3{MAX_POS}});
		drain();

		set_box_count(4);
		push_query({3{32'd0}});
		push_query({3{ONE_Q}});
		push_query({3{-ONE_Q}});
		push_query({3{-(ONE_Q + 32'd1)}});
		push_query({3{MIN_NEG}});
		push_query({3{MAX_POS}});
		push_query({32'd0, -(ONE_Q + 32'd1), ONE_Q + 32'd1});
		push_query({3{32'hFFFF_FFFF}});
		push_write(15, {32'd0, 32'd0, 32'd0}, {3{ONE_Q}});
		drain();

		// box 2 lies outside the scan now
		set_box_count(2);
		push_query({3{-(ONE_Q + 32'd1)}});
		push_query({3{32'd0}});
		for (int s = 0; s < MAX_BOXES; s++)
			rand_box(s);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			v = (ph < 6) ? fixed_counts[ph] : $urandom_range(0, 31);
			set_box_count(v);
			if (v > MAX_BOXES)
				v = MAX_BOXES;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 3) == 0)
					rand_box($urandom_range(0, MAX_BOXES - 1));
				else
					rand_query(v);
			end
			drain();
		end

		$display("%0d box writes and %0d point queries checked, %0d of the queries hit",
			n_writes, n_queries, n_hits);
		$display("box_count swept from 0 to 31, with inside-out, full-range and edge boxes");
		if (n_errors == 0)
			$display("point_in_box_first_hit_tb passed");
		else
			$display("point_in_box_first_hit_tb failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/pibfh_pkg.sv
src/pibfh_box_mem.sv
src/pibfh_box_test.sv
src/pibfh_seq.sv
src/point_in_box_first_hit.sv
src/pibfh_checker.sv
test/point_in_box_first_hit_tb.sv
